// ===== rtl/tmcw_pkg.sv =====
// Shared constants, register codes, control structs and address helpers
// for the text-mode console writer. No dependencies.
package tmcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int SUM_W  = ADDR_W + 1;

   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int IDX_W      = 11;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int CELL_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TEXT_ATTR      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RETURN_CODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BACKSPACE_CODE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DELETE_CODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MICRO_CODE     = 3'd4;

   localparam logic [CHAR_W-1:0] TEXT_ATTR_RST      = 8'h07;
   localparam logic [CHAR_W-1:0] RETURN_CODE_RST    = 8'd10;
   localparam logic [CHAR_W-1:0] BACKSPACE_CODE_RST = 8'd8;
   localparam logic [CHAR_W-1:0] DELETE_CODE_RST    = 8'd127;
   localparam logic [CHAR_W-1:0] MICRO_CODE_RST     = 8'd181;

   localparam logic [CHAR_W-1:0] MICRO_GLYPH = 8'hE6;
   localparam logic [CELL_W-1:0] SCROLL_FILL = 16'h0700;

   typedef struct packed {
      logic [CHAR_W-1:0] text_attr;
      logic [CHAR_W-1:0] return_code;
      logic [CHAR_W-1:0] backspace_code;
      logic [CHAR_W-1:0] delete_code;
      logic [CHAR_W-1:0] micro_code;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic mem_write;
      logic mem_read;
      logic sweep_step;
      logic respond;
   } ctl_cmd_type;

   typedef struct packed {
      logic op_write;
      logic op_read;
      logic sweep_now;
      logic scroll_pending;
      logic sweep_last;
   } dp_status_type;

   // Screen rows live in a ring; base is the physical address of the top row.
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [SUM_W-1:0] lin,
                                                   input logic [ADDR_W-1:0] base);
      logic [SUM_W-1:0] sum;
      sum = lin + SUM_W'(base);
      if (sum >= SUM_W'(CELLS)) begin
         sum = sum - SUM_W'(CELLS);
      end
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] lin_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
      return SUM_W'(row) * SUM_W'(COLUMNS) + SUM_W'(col);
   endfunction

endpackage

// ===== rtl/tmcw_regs.sv =====
// Configuration registers of the console writer, written through a plain
// write port. Depends on tmcw_pkg.
module tmcw_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tmcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tmcw_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tmcw_pkg::cfg_type                cfg
);
   import tmcw_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_attr      <= TEXT_ATTR_RST;
         cfg_ff.return_code    <= RETURN_CODE_RST;
         cfg_ff.backspace_code <= BACKSPACE_CODE_RST;
         cfg_ff.delete_code    <= DELETE_CODE_RST;
         cfg_ff.micro_code     <= MICRO_CODE_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_TEXT_ATTR:      cfg_ff.text_attr      <= csr_wdata;
            REG_RETURN_CODE:    cfg_ff.return_code    <= csr_wdata;
            REG_BACKSPACE_CODE: cfg_ff.backspace_code <= csr_wdata;
            REG_DELETE_CODE:    cfg_ff.delete_code    <= csr_wdata;
            REG_MICRO_CODE:     cfg_ff.micro_code     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tmcw_ctrl.sv =====
// Sequencing state machine of the console writer: reset fill, decode,
// cell write or read, row/screen fill sweep, result beat. Depends on tmcw_pkg.
module tmcw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  tmcw_pkg::dp_status_type  status,
   output tmcw_pkg::ctl_cmd_type    cmd
);
   import tmcw_pkg::*;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_SWEEP = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.op_write) begin
               state_in = S_WRITE;
            end else if (status.op_read) begin
               state_in = S_READ;
            end else if (status.sweep_now) begin
               state_in = S_SWEEP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in = status.scroll_pending ? S_SWEEP : S_RESP;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
            state_in = S_RESP;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/tmcw_datapath.sv =====
// Datapath of the console writer: screen store (row ring), cursor, address
// generation, fill sweep and result registers. Depends on tmcw_pkg.
module tmcw_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  tmcw_pkg::ctl_cmd_type          cmd,
   output tmcw_pkg::dp_status_type        status,
   input  tmcw_pkg::cfg_type              cfg,
   input  logic [tmcw_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tmcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tmcw_pkg::IDX_W-1:0]     req_cell_index,
   output logic                           rsp_strobe,
   output logic [tmcw_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tmcw_pkg::ROW_W-1:0]     rsp_cursor_row,
   output logic [tmcw_pkg::CELL_W-1:0]    rsp_cell_data,
   output logic                           rsp_scrolled
);
   import tmcw_pkg::*;

   logic [CELL_W-1:0] mem [0:CELLS-1];

   logic [CMD_W-1:0]  cmd_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [ADDR_W-1:0] top_base_ff;
   logic              scroll_ff;
   logic              read_ok_ff;
   logic              strobe_ff;

   logic [ADDR_W-1:0] sweep_addr_ff;
   logic [ADDR_W-1:0] sweep_left_ff;
   logic [CELL_W-1:0] fill_ff;

   logic [ADDR_W-1:0] addr_ff;
   logic [CELL_W-1:0] wdata_ff;
   logic [CELL_W-1:0] rdata_ff;

   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [CELL_W-1:0] rsp_data_ff;
   logic              rsp_scrolled_ff;

   logic              is_put, is_ret, is_bs, is_del, is_wr;
   logic              clear_now, read_ok_now, scroll_now, row_inc;
   logic              col_last, row_last;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_in;
   logic [COL_W-1:0]  tgt_col;
   logic [ROW_W-1:0]  tgt_row;
   logic [CHAR_W-1:0] glyph;
   logic [CELL_W-1:0] wr_data;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [SUM_W-1:0]  top_sum;
   logic [ADDR_W-1:0] top_base_in;

   // code priority: return, backspace, delete, then ordinary write
   assign is_put    = (cmd_ff == CMD_PUT);
   assign is_ret    = (char_ff == cfg.return_code);
   assign is_bs     = !is_ret && (char_ff == cfg.backspace_code);
   assign is_del    = !is_ret && !is_bs && (char_ff == cfg.delete_code);
   assign is_wr     = !is_ret && !is_bs && !is_del;
   assign clear_now = (cmd_ff == CMD_CLEAR);
   assign read_ok_now = (cmd_ff == CMD_READ) && (int'(idx_ff) < CELLS);

   assign col_last = (col_ff == COL_W'(COLUMNS - 1));
   assign row_last = (row_ff == ROW_W'(ROWS - 1));

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      row_inc    = 1'b0;
      scroll_now = 1'b0;
      if (is_put) begin
         if (is_ret) begin
            col_in  = '0;
            row_inc = 1'b1;
         end else if (is_bs) begin
            if (col_ff != '0) begin
               col_in = col_ff - COL_W'(1);
            end else if (row_ff != '0) begin
               row_in = row_ff - ROW_W'(1);
               col_in = COL_W'(COLUMNS - 1);
            end
         end else if (is_wr) begin
            if (col_last) begin
               col_in  = '0;
               row_inc = 1'b1;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
      // past the last row: scroll and stay on the bottom row
      if (row_inc) begin
         if (row_last) begin
            scroll_now = 1'b1;
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
   end

   // backspace blanks the cell it lands on; a write uses the old cursor
   assign tgt_col = is_bs ? col_in : col_ff;
   assign tgt_row = is_bs ? row_in : row_ff;
   assign glyph   = (char_ff == cfg.micro_code) ? MICRO_GLYPH : char_ff;
   assign wr_data = {cfg.text_attr, (is_bs ? {CHAR_W{1'b0}} : glyph)};
   assign wr_addr = phys_addr(lin_addr(tgt_row, tgt_col), top_base_ff);
   assign rd_addr = phys_addr(SUM_W'(idx_ff), top_base_ff);

   assign top_sum     = SUM_W'(top_base_ff) + SUM_W'(COLUMNS);
   assign top_base_in = (top_sum >= SUM_W'(CELLS)) ? '0 : top_sum[ADDR_W-1:0];

   assign status.op_write       = is_put && (is_bs || is_wr);
   assign status.op_read        = (cmd_ff == CMD_READ);
   assign status.sweep_now      = clear_now || scroll_now;
   assign status.scroll_pending = scroll_ff;
   assign status.sweep_last     = (sweep_left_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         top_base_ff   <= '0;
         scroll_ff     <= 1'b0;
         read_ok_ff    <= 1'b0;
         strobe_ff     <= 1'b0;
         sweep_addr_ff <= '0;
         sweep_left_ff <= ADDR_W'(CELLS - 1);
         fill_ff       <= SCROLL_FILL;
      end else begin
         strobe_ff <= cmd.respond;
         if (cmd.load) begin
            scroll_ff  <= 1'b0;
            read_ok_ff <= 1'b0;
         end
         if (cmd.exec) begin
            scroll_ff  <= scroll_now;
            read_ok_ff <= read_ok_now;
            if (clear_now) begin
               col_ff        <= '0;
               row_ff        <= '0;
               top_base_ff   <= '0;
               sweep_addr_ff <= '0;
               sweep_left_ff <= ADDR_W'(CELLS - 1);
               fill_ff       <= {cfg.text_attr, {CHAR_W{1'b0}}};
            end else begin
               col_ff <= col_in;
               row_ff <= row_in;
               if (scroll_now) begin
                  // old top row becomes the new bottom row
                  sweep_addr_ff <= top_base_ff;
                  sweep_left_ff <= ADDR_W'(COLUMNS - 1);
                  fill_ff       <= SCROLL_FILL;
                  top_base_ff   <= top_base_in;
               end
            end
         end
         if (cmd.sweep_step && (sweep_left_ff != '0)) begin
            sweep_addr_ff <= sweep_addr_ff + ADDR_W'(1);
            sweep_left_ff <= sweep_left_ff - ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index;
      end
      if (cmd.exec) begin
         addr_ff  <= (cmd_ff == CMD_READ) ? rd_addr : wr_addr;
         wdata_ff <= wr_data;
      end
      if (cmd.respond) begin
         rsp_col_ff      <= col_ff;
         rsp_row_ff      <= row_ff;
         rsp_data_ff     <= read_ok_ff ? rdata_ff : '0;
         rsp_scrolled_ff <= scroll_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[addr_ff] <= wdata_ff;
      end else if (cmd.sweep_step) begin
         mem[sweep_addr_ff] <= fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

endmodule

// ===== rtl/text_mode_console_writer.sv =====
// Top level of the text-mode console writer: configuration registers,
// controller and datapath. Depends on tmcw_pkg, tmcw_regs, tmcw_ctrl, tmcw_datapath.
//
// A command is taken when start is high and busy is low; each command gives
// exactly one result beat on rsp_strobe, which the receiver must take in that
// cycle. After reset the block is busy while it fills the screen store with
// blank 0x0700 cells, one cell per cycle through the single write port. A put
// or read goes through decode, the cell write or read and the respond state
// before the block is idle again (return and ignored codes skip the cell
// access); the result beat is registered from the respond state. A put that
// scrolls also sweeps a fill over the recycled row only, since rows sit in a
// ring. A clear sweeps a fill over the full store. Configuration writes take
// effect at once and are taken at any time.
module text_mode_console_writer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tmcw_pkg::CMD_W-1:0]       req_cmd,
   input  logic [tmcw_pkg::CHAR_W-1:0]      req_char_code,
   input  logic [tmcw_pkg::IDX_W-1:0]       req_cell_index,
   output logic                             rsp_strobe,
   output logic [tmcw_pkg::COL_W-1:0]       rsp_cursor_col,
   output logic [tmcw_pkg::ROW_W-1:0]       rsp_cursor_row,
   output logic [tmcw_pkg::CELL_W-1:0]      rsp_cell_data,
   output logic                             rsp_scrolled,
   input  logic                             csr_we,
   input  logic [tmcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tmcw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tmcw_pkg::*;

   cfg_type       cfg;
   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   tmcw_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tmcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (ctl_cmd)
   );

   tmcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctl_cmd),
      .status         (dp_status),
      .cfg            (cfg),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_scrolled   (rsp_scrolled)
   );

endmodule

// ===== tb/sv/tb_text_mode_console_writer.sv =====
// Self-checking testbench for text_mode_console_writer: put, clear, read and
// spare commands against an in-bench screen predictor, across register settings.
// Depends on tmcw_pkg and the text_mode_console_writer RTL.
module tb_text_mode_console_writer;
   import tmcw_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int STALL_LIMIT = 12000;
   localparam int BURST_LEN   = 305;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] ch;
      logic [IDX_W-1:0]  idx;
   } console_cmd_type;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [CELL_W-1:0] data;
      logic              scrolled;
   } console_status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_cmd = '0;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic [IDX_W-1:0]      req_cell_index = '0;
   logic                  rsp_strobe;
   logic [COL_W-1:0]      rsp_cursor_col;
   logic [ROW_W-1:0]      rsp_cursor_row;
   logic [CELL_W-1:0]     rsp_cell_data;
   logic                  rsp_scrolled;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   console_cmd_type    cmd_backlog[$];
   console_status_type pending_replies[$];
   logic            req_taken = 1'b0;
   logic            no_gap = 1'b0;
   int              idle_cycles = 0;
   int              err_count = 0;
   int              n_cmds = 0, n_puts = 0, n_reads = 0, n_clears = 0, n_scrolls = 0;
   int              n_settings = 1;

   // predicted screen, cursor and register copies
   logic [CELL_W-1:0] screen_img [CELLS];
   int                cur_col, cur_row;
   logic [CHAR_W-1:0] cur_attr, ret_char, bs_char, del_char, micro_key;

   text_mode_console_writer u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cell_data  (rsp_cell_data),
      .rsp_scrolled   (rsp_scrolled),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic console_status_type console_apply(input console_cmd_type c);
      console_status_type r;
      logic [CHAR_W-1:0] glyph;
      r = '0;
      case (c.cmd)
         CMD_PUT: begin
            if (c.ch == ret_char) begin
               cur_row++;
               cur_col = 0;
            end else if (c.ch == bs_char) begin
               if (cur_col > 0) begin
                  cur_col--;
               end else if (cur_row > 0) begin
                  cur_row--;
                  cur_col = COLUMNS - 1;
               end
               screen_img[cur_row * COLUMNS + cur_col] = {cur_attr, 8'h00};
            end else if (c.ch != del_char) begin
               glyph = (c.ch == micro_key) ? MICRO_GLYPH : c.ch;
               screen_img[cur_row * COLUMNS + cur_col] = {cur_attr, glyph};
               cur_col++;
               if (cur_col >= COLUMNS) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            if (cur_row >= ROWS) begin
               for (int i = 0; i < CELLS; i++) begin
                  screen_img[i] = (i + COLUMNS < CELLS) ? screen_img[i + COLUMNS] : SCROLL_FILL;
               end
               cur_row = ROWS - 1;
               r.scrolled = 1'b1;
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen_img[i] = {cur_attr, 8'h00};
            end
            cur_col = 0;
            cur_row = 0;
         end
         CMD_READ: begin
            if (c.idx < CELLS) begin
               r.data = screen_img[c.idx];
            end
         end
         default: begin
         end
      endcase
      r.col = cur_col[COL_W-1:0];
      r.row = cur_row[ROW_W-1:0];
      return r;
   endfunction

   task automatic flag_mismatch(input string field, input int got, input int want);
      $display("mismatch on beat %0d: %s got 0x%0h, predicted 0x%0h", n_cmds, field, got, want);
      err_count++;
   endtask

   function automatic void push_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                    input logic [IDX_W-1:0] idx);
      console_cmd_type c;
      c.cmd = cmd;
      c.ch  = ch;
      c.idx = idx;
      cmd_backlog.push_back(c);
   endfunction

   task automatic queue_random_burst(input int n);
      int pick, sub;
      logic [IDX_W-1:0] where;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 58) begin
            push_cmd(CMD_PUT, CHAR_W'($urandom), IDX_W'($urandom));
         end else if (pick < 66) begin
            push_cmd(CMD_PUT, ret_char, IDX_W'($urandom));
         end else if (pick < 74) begin
            push_cmd(CMD_PUT, bs_char, IDX_W'($urandom));
         end else if (pick < 78) begin
            push_cmd(CMD_PUT, del_char, IDX_W'($urandom));
         end else if (pick < 82) begin
            push_cmd(CMD_PUT, micro_key, IDX_W'($urandom));
         end else if (pick < 96) begin
            sub = $urandom_range(9);
            if (sub < 4) begin
               where = IDX_W'($urandom_range(CELLS - 1));
            end else if (sub < 9) begin
               // bottom rows are where text piles up after scrolling
               where = IDX_W'($urandom_range(CELLS - 1, CELLS - 5 * COLUMNS));
            end else begin
               where = IDX_W'($urandom_range(2 ** IDX_W - 1, CELLS));
            end
            push_cmd(CMD_READ, CHAR_W'($urandom), where);
         end else if (pick < 98) begin
            push_cmd(CMD_SPARE, CHAR_W'($urandom), IDX_W'($urandom));
         end else if (pick < 99) begin
            push_cmd(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
         end else begin
            push_cmd(CMD_PUT, CHAR_W'($urandom_range(126, 32)), IDX_W'($urandom));
         end
      end
   endtask

   task automatic drain_replies();
      while (cmd_backlog.size() != 0 || start || pending_replies.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic program_console(input logic [CHAR_W-1:0] attr, input logic [CHAR_W-1:0] ret,
                                  input logic [CHAR_W-1:0] bs, input logic [CHAR_W-1:0] del,
                                  input logic [CHAR_W-1:0] micro);
      csr_write(REG_TEXT_ATTR, attr);
      csr_write(REG_RETURN_CODE, ret);
      csr_write(REG_BACKSPACE_CODE, bs);
      csr_write(REG_DELETE_CODE, del);
      csr_write(REG_MICRO_CODE, micro);
      @(negedge clock);
      csr_we     <= 1'b0;
      cur_attr   = attr;
      ret_char   = ret;
      bs_char    = bs;
      del_char   = del;
      micro_key  = micro;
      n_settings++;
   endtask

   // driver: next beat from the backlog, with random gaps unless no_gap is set
   always @(negedge clock) begin : drv
      console_cmd_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (cmd_backlog.size() != 0 && (no_gap || $urandom_range(99) >= 38)) begin
            nxt = cmd_backlog.pop_front();
            start          <= 1'b1;
            req_cmd        <= nxt.cmd;
            req_char_code  <= nxt.ch;
            req_cell_index <= nxt.idx;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on each accepted beat, check each result beat
   always @(posedge clock) begin : mon
      console_cmd_type    seen;
      console_status_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (start && !busy) begin
            seen.cmd = req_cmd;
            seen.ch  = req_char_code;
            seen.idx = req_cell_index;
            want = console_apply(seen);
            pending_replies.push_back(want);
            n_cmds++;
            if (seen.cmd == CMD_PUT) n_puts++;
            if (seen.cmd == CMD_READ) n_reads++;
            if (seen.cmd == CMD_CLEAR) n_clears++;
            if (want.scrolled) n_scrolls++;
         end
         if (rsp_strobe) begin
            if (pending_replies.size() == 0) begin
               flag_mismatch("unexpected result beat", 1, 0);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_cursor_col !== want.col)
                  flag_mismatch("cursor_col", rsp_cursor_col, want.col);
               if (rsp_cursor_row !== want.row)
                  flag_mismatch("cursor_row", rsp_cursor_row, want.row);
               if (rsp_cell_data !== want.data)
                  flag_mismatch("cell_data", rsp_cell_data, want.data);
               if (rsp_scrolled !== want.scrolled)
                  flag_mismatch("scrolled", rsp_scrolled, want.scrolled);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("no beat for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_replies.size());
         $display("text_mode_console_writer verification failed");
         $finish;
      end
   end

   initial begin : main
      for (int i = 0; i < CELLS; i++) begin
         screen_img[i] = SCROLL_FILL;
      end
      cur_col    = 0;
      cur_row    = 0;
      cur_attr   = TEXT_ATTR_RST;
      ret_char   = RETURN_CODE_RST;
      bs_char    = BACKSPACE_CODE_RST;
      del_char   = DELETE_CODE_RST;
      micro_key  = MICRO_CODE_RST;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: index extremes, spare command, backspace at home and at line start
      push_cmd(CMD_READ, 8'h00, 11'd0);
      push_cmd(CMD_READ, 8'h00, 11'(CELLS - 1));
      push_cmd(CMD_READ, 8'h00, 11'(CELLS));
      push_cmd(CMD_READ, 8'hFF, 11'h7FF);
      push_cmd(CMD_SPARE, 8'hFF, 11'h7FF);
      push_cmd(CMD_PUT, BACKSPACE_CODE_RST, 11'd0);
      push_cmd(CMD_PUT, 8'h41, 11'd0);
      push_cmd(CMD_PUT, 8'h00, 11'd0);
      push_cmd(CMD_PUT, 8'hFF, 11'd0);
      push_cmd(CMD_PUT, MICRO_CODE_RST, 11'd0);
      push_cmd(CMD_PUT, DELETE_CODE_RST, 11'd0);
      for (int i = 0; i < 4; i++) begin
         push_cmd(CMD_READ, 8'h00, 11'(i));
      end
      push_cmd(CMD_PUT, RETURN_CODE_RST, 11'd0);
      push_cmd(CMD_PUT, BACKSPACE_CODE_RST, 11'd0);
      push_cmd(CMD_READ, 8'h00, 11'(COLUMNS - 1));
      push_cmd(CMD_PUT, 8'h5A, 11'd0);
      push_cmd(CMD_READ, 8'h00, 11'(COLUMNS - 1));
      push_cmd(CMD_CLEAR, 8'h00, 11'd0);
      push_cmd(CMD_READ, 8'h00, 11'd0);
      push_cmd(CMD_PUT, 8'h20, 11'd0);
      push_cmd(CMD_READ, 8'h00, 11'd0);
      queue_random_burst(BURST_LEN);
      drain_replies();

      program_console(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01);
      queue_random_burst(BURST_LEN);
      drain_replies();

      // backspace and delete collide: backspace wins
      program_console(8'h00, 8'hFF, 8'h00, 8'h00, 8'h7F);
      queue_random_burst(BURST_LEN);
      drain_replies();

      // all codes collide: return wins, micro never applies
      program_console(8'h1E, 8'h41, 8'h41, 8'h41, 8'h41);
      queue_random_burst(BURST_LEN);
      drain_replies();

      no_gap <= 1'b1;
      program_console(CHAR_W'($urandom), CHAR_W'($urandom), CHAR_W'($urandom),
                      CHAR_W'($urandom), CHAR_W'($urandom));
      queue_random_burst(BURST_LEN);
      drain_replies();
      no_gap <= 1'b0;

      program_console(8'h4F, RETURN_CODE_RST, BACKSPACE_CODE_RST, DELETE_CODE_RST,
                      MICRO_CODE_RST);
      queue_random_burst(BURST_LEN);
      drain_replies();
      repeat (16) @(negedge clock);

      $display("%0d commands checked under %0d register settings", n_cmds, n_settings);
      $display("%0d puts with %0d scrolls, %0d reads, %0d clears, %0d mismatches",
               n_puts, n_scrolls, n_reads, n_clears, err_count);
      if (err_count == 0) begin
         $display("text_mode_console_writer verification clean");
      end else begin
         $display("text_mode_console_writer verification failed");
      end
      $finish;
   end

endmodule
